>>> rtl/izhikevich_neuron_with_synapses_macros.svh
// Assertion macros for the design file.
`ifndef IZHIKEVICH_NEURON_WITH_SYNAPSES_MACROS_SVH
`define IZHIKEVICH_NEURON_WITH_SYNAPSES_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define INS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define INS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/ins_pkg.sv
package ins_pkg;

   // Model constants in signed Q16.16.
   localparam logic signed [31:0] K_004 = 32'sd2621;
   localparam logic signed [31:0] K_5 = 32'sd327680;
   localparam logic signed [31:0] K_140 = 32'sd9175040;
   localparam logic signed [31:0] K_30 = 32'sd1966080;

   // Per-neuron state after reset.
   localparam logic signed [31:0] V_RESET = -32'sd3932160;
   localparam logic signed [31:0] U_RESET = -32'sd786432;

   // Register reset values.
   localparam logic signed [31:0] PARAM_A_RESET = 32'sd1311;
   localparam logic signed [31:0] PARAM_B_RESET = 32'sd13107;
   localparam logic signed [31:0] PARAM_C_RESET = -32'sd4259840;
   localparam logic signed [31:0] PARAM_D_RESET = 32'sd524288;

   // Configuration register indexes.
   typedef enum logic [3:0] {
      CSR_PARAM_A  = 4'd0,
      CSR_PARAM_B  = 4'd1,
      CSR_PARAM_C  = 4'd2,
      CSR_PARAM_D  = 4'd3,
      CSR_EXC_RATE = 4'd4,
      CSR_INH_RATE = 4'd5,
      CSR_EXC_GAIN = 4'd6,
      CSR_INH_GAIN = 4'd7
   } csr_index_type;

   // Control state: clearing pass, then normal operation.
   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // One memory word holds the whole state of a neuron.
   typedef struct packed {
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic signed [31:0] ae;
      logic signed [31:0] ai;
      logic signed [31:0] an;
      logic signed [31:0] syn;
   } neuron_type;

   // Saturate a wide signed value to Q16.16.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Q16.16 product, floored and saturated.
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return sat32(p >>> 16);
   endfunction

endpackage

>>> rtl/izhikevich_neuron_with_synapses.sv
// Time-multiplexed Izhikevich neurons with conductance synapses.
// The req channel carries one Euler tick for one neuron: its index, spike
// counts and external current. The rsp channel returns one word per tick with
// the index, the spike flag and the new membrane potential, in request order.
// The csr channel writes the model registers; csr_ready is always high and
// writes are meant to happen while no tick is in flight.
// One tick is accepted per cycle while consecutive ticks touch different neurons
// and the receiver does not stall the pipeline; a tick for a neuron still in the
// pipeline waits in the entry stage until the earlier write-back to the state
// memory has landed.
// All neuron state lives in one memory word per neuron, read once at entry and
// written back once at the end of the pipeline.
// After reset the block runs a clearing pass that writes the reset state into
// every entry; req_ready stays low until it ends.
// When the receiver stalls, the output register holds its word and earlier
// stages keep filling until the pipeline is full, then req_ready drops.
`include "izhikevich_neuron_with_synapses_macros.svh"

module izhikevich_neuron_with_synapses #(
   parameter int NEURONS    = 1024,
   parameter int PRESYN     = 64,
   parameter int DT_SHIFT   = 4,
   parameter int E_EXC      = 0,
   parameter int E_INH      = -70,
   parameter int NOISE_GAIN = 655
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_neuron_index,
   input  logic [6:0]         req_exc_spikes,
   input  logic [6:0]         req_inh_spikes,
   input  logic [7:0]         req_noise_spikes,
   input  logic signed [31:0] req_ext_current,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_neuron_out,
   output logic               rsp_spiked,
   output logic signed [31:0] rsp_potential,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int RECIP = (1 << 20) / NEURONS;

   // Configuration registers.
   logic signed [31:0] param_a_ff, param_b_ff, param_c_ff, param_d_ff;
   logic [15:0]        exc_rate_ff, inh_rate_ff;
   logic [23:0]        exc_gain_ff, inh_gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         param_a_ff  <= ins_pkg::PARAM_A_RESET;
         param_b_ff  <= ins_pkg::PARAM_B_RESET;
         param_c_ff  <= ins_pkg::PARAM_C_RESET;
         param_d_ff  <= ins_pkg::PARAM_D_RESET;
         exc_rate_ff <= '0;
         inh_rate_ff <= '0;
         exc_gain_ff <= '0;
         inh_gain_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ins_pkg::CSR_PARAM_A:  param_a_ff  <= csr_data;
            ins_pkg::CSR_PARAM_B:  param_b_ff  <= csr_data;
            ins_pkg::CSR_PARAM_C:  param_c_ff  <= csr_data;
            ins_pkg::CSR_PARAM_D:  param_d_ff  <= csr_data;
            ins_pkg::CSR_EXC_RATE: exc_rate_ff <= csr_data[15:0];
            ins_pkg::CSR_INH_RATE: inh_rate_ff <= csr_data[15:0];
            ins_pkg::CSR_EXC_GAIN: exc_gain_ff <= csr_data[23:0];
            ins_pkg::CSR_INH_GAIN: inh_gain_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Clearing pass control.
   ins_pkg::state_type state_ff;
   logic [IW-1:0]      clr_ff;
   logic               clear_done;

   assign clear_done = (clr_ff == IW'(NEURONS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ins_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            ins_pkg::ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clear_done) begin
                  state_ff <= ins_pkg::ST_RUN;
               end
            end
            ins_pkg::ST_RUN: ;
            default: state_ff <= ins_pkg::ST_CLEAR;
         endcase
      end
   end

   // Pipeline valid bits and handshake signals.
   logic va_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic move_a, move1, move2, move3, move4, move5, move6;
   logic free1, free2, free3, free4, free5, free6, free_out;
   logic hazard, accept;

   assign free_out = !rsp_valid_ff || rsp_ready;
   assign move6 = v6_ff && free_out;
   assign free6 = !v6_ff || move6;
   assign move5 = v5_ff && free6;
   assign free5 = !v5_ff || move5;
   assign move4 = v4_ff && free5;
   assign free4 = !v4_ff || move4;
   assign move3 = v3_ff && free4;
   assign free3 = !v3_ff || move3;
   assign move2 = v2_ff && free3;
   assign free2 = !v2_ff || move2;
   assign move1 = v1_ff && free2;
   assign free1 = !v1_ff || move1;
   assign move_a = va_ff && free1 && !hazard;
   assign req_ready = (state_ff == ins_pkg::ST_RUN) && (!va_ff || move_a);
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         va_ff <= accept || (va_ff && !move_a);
         v1_ff <= move_a || (v1_ff && !move1);
         v2_ff <= move1 || (v2_ff && !move2);
         v3_ff <= move2 || (v3_ff && !move3);
         v4_ff <= move3 || (v4_ff && !move4);
         v5_ff <= move4 || (v5_ff && !move5);
         v6_ff <= move5 || (v6_ff && !move6);
         rsp_valid_ff <= move6 || (rsp_valid_ff && !rsp_ready);
      end
   end

   // Entry stage: clamp the counts and start the index reduction.
   logic [9:0]         raw_a_ff;
   logic [9:0]         q_a_ff;
   logic [6:0]         ne_a_ff, ni_a_ff;
   logic [7:0]         nn_a_ff;
   logic signed [31:0] ext_a_ff;
   logic [30:0]        q_prod;

   assign q_prod = 31'(req_neuron_index) * 31'(RECIP);

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_a_ff <= req_neuron_index;
         q_a_ff   <= 10'(q_prod >> 20);
         ne_a_ff  <= (32'(req_exc_spikes) > PRESYN) ? 7'(PRESYN) : req_exc_spikes;
         ni_a_ff  <= (32'(req_inh_spikes) > PRESYN) ? 7'(PRESYN) : req_inh_spikes;
         nn_a_ff  <= req_noise_spikes;
         ext_a_ff <= req_ext_current;
      end
   end

   // Finish the modulo: the quotient estimate is at most one low.
   logic [26:0]   rem_a;
   logic [IW-1:0] k_a;

   assign rem_a = 27'(raw_a_ff) - 27'(q_a_ff) * 27'(NEURONS);
   assign k_a = (rem_a >= 27'(NEURONS)) ? IW'(rem_a - 27'(NEURONS)) : IW'(rem_a);

   // Neuron indexes held further down, for the same-neuron interlock.
   logic [IW-1:0] k1_ff, k2_ff, k3_ff, k4_ff, k5_ff, k6_ff;

   assign hazard = (v1_ff && k1_ff == k_a) || (v2_ff && k2_ff == k_a) ||
                   (v3_ff && k3_ff == k_a) || (v4_ff && k4_ff == k_a) ||
                   (v5_ff && k5_ff == k_a) || (v6_ff && k6_ff == k_a);

   // State memory: one read port at entry, one write port at write-back.
   ins_pkg::neuron_type mem [NEURONS];
   ins_pkg::neuron_type rd_ff;
   ins_pkg::neuron_type wr_word;
   ins_pkg::neuron_type clr_word;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic signed [31:0]  isum;
   logic signed [31:0]  vn6_ff, un6_ff, ae6_ff, ai6_ff, an6_ff;

   assign clr_word = '{v: ins_pkg::V_RESET, u: ins_pkg::U_RESET,
                       ae: '0, ai: '0, an: '0, syn: '0};

   always_comb begin
      if (state_ff == ins_pkg::ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_word = clr_word;
      end else begin
         wr_en   = move6;
         wr_addr = k6_ff;
         wr_word = '{v: vn6_ff, u: un6_ff, ae: ae6_ff, ai: ai6_ff,
                     an: an6_ff, syn: isum};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (move_a) begin
         rd_ff <= mem[k_a];
      end
   end

   // Stage 1: square, linear terms and synapse decay steps.
   logic [9:0]         raw1_ff;
   logic [6:0]         ne1_ff, ni1_ff;
   logic [7:0]         nn1_ff;
   logic signed [31:0] ext1_ff;
   logic signed [33:0] diff_e, diff_i, diff_n;
   logic signed [50:0] prod_e, prod_i, prod_n;

   always_ff @(posedge clock) begin
      if (move_a) begin
         raw1_ff <= raw_a_ff;
         k1_ff   <= k_a;
         ne1_ff  <= ne_a_ff;
         ni1_ff  <= ni_a_ff;
         nn1_ff  <= nn_a_ff;
         ext1_ff <= ext_a_ff;
      end
   end

   assign diff_e = $signed({11'b0, ne1_ff, 16'b0}) - 34'(rd_ff.ae);
   assign diff_i = $signed({11'b0, ni1_ff, 16'b0}) - 34'(rd_ff.ai);
   assign diff_n = $signed({10'b0, nn1_ff, 16'b0}) - 34'(rd_ff.an);
   assign prod_e = diff_e * $signed({1'b0, exc_rate_ff});
   assign prod_i = diff_i * $signed({1'b0, inh_rate_ff});
   assign prod_n = diff_n * $signed({1'b0, exc_rate_ff});

   logic [9:0]         raw2_ff;
   logic signed [31:0] ext2_ff, v2_st_ff, u2_ff, ae2_ff, ai2_ff, an2_ff, syn2_ff;
   logic signed [31:0] vv2_ff, p52_ff, bv2_ff;
   logic signed [34:0] se2_ff, si2_ff, sn2_ff;

   always_ff @(posedge clock) begin
      if (move1) begin
         raw2_ff  <= raw1_ff;
         k2_ff    <= k1_ff;
         ext2_ff  <= ext1_ff;
         v2_st_ff <= rd_ff.v;
         u2_ff    <= rd_ff.u;
         ae2_ff   <= rd_ff.ae;
         ai2_ff   <= rd_ff.ai;
         an2_ff   <= rd_ff.an;
         syn2_ff  <= rd_ff.syn;
         vv2_ff   <= ins_pkg::mulq(rd_ff.v, rd_ff.v);
         p52_ff   <= ins_pkg::mulq(ins_pkg::K_5, rd_ff.v);
         bv2_ff   <= ins_pkg::mulq(param_b_ff, rd_ff.v);
         se2_ff   <= 35'(prod_e >>> 16);
         si2_ff   <= 35'(prod_i >>> 16);
         sn2_ff   <= 35'(prod_n >>> 16);
      end
   end

   // Stage 2: quadratic term, recovery drive and new activations.
   logic [9:0]         raw3_ff;
   logic signed [31:0] ext3_ff, v3_st_ff, u3_ff, syn3_ff, t13_ff, p53_ff, w3_ff;
   logic signed [31:0] ae3_ff, ai3_ff, an3_ff;

   always_ff @(posedge clock) begin
      if (move2) begin
         raw3_ff  <= raw2_ff;
         k3_ff    <= k2_ff;
         ext3_ff  <= ext2_ff;
         v3_st_ff <= v2_st_ff;
         u3_ff    <= u2_ff;
         syn3_ff  <= syn2_ff;
         t13_ff   <= ins_pkg::mulq(ins_pkg::K_004, vv2_ff);
         p53_ff   <= p52_ff;
         w3_ff    <= ins_pkg::sat32(64'(bv2_ff) - 64'(u2_ff));
         ae3_ff   <= ins_pkg::sat32(64'(ae2_ff) + 64'(se2_ff));
         ai3_ff   <= ins_pkg::sat32(64'(ai2_ff) + 64'(si2_ff));
         an3_ff   <= ins_pkg::sat32(64'(an2_ff) + 64'(sn2_ff));
      end
   end

   // Stage 3: potential derivative, recovery derivative, conductances.
   logic [9:0]         raw4_ff;
   logic signed [31:0] v4_st_ff, u4_ff, dv4_ff, du4_ff;
   logic signed [31:0] ae4_ff, ai4_ff, an4_ff, rge4_ff, rgi4_ff, rgn4_ff;

   always_ff @(posedge clock) begin
      if (move3) begin
         raw4_ff  <= raw3_ff;
         k4_ff    <= k3_ff;
         v4_st_ff <= v3_st_ff;
         u4_ff    <= u3_ff;
         dv4_ff   <= ins_pkg::sat32(64'(t13_ff) + 64'(p53_ff) + 64'(ins_pkg::K_140)
                                    - 64'(u3_ff) + 64'(syn3_ff) + 64'(ext3_ff));
         du4_ff   <= ins_pkg::mulq(param_a_ff, w3_ff);
         ae4_ff   <= ae3_ff;
         ai4_ff   <= ai3_ff;
         an4_ff   <= an3_ff;
         rge4_ff  <= ins_pkg::mulq(ae3_ff, $signed({8'b0, exc_gain_ff}));
         rgi4_ff  <= ins_pkg::mulq(ai3_ff, $signed({8'b0, inh_gain_ff}));
         rgn4_ff  <= ins_pkg::mulq(an3_ff, 32'(NOISE_GAIN));
      end
   end

   // Stage 4: Euler step, threshold and spike reset.
   logic signed [31:0] vn_step, un_step, vn_in, un_in;
   logic               spike_in;

   always_comb begin
      vn_step  = ins_pkg::sat32(64'(v4_st_ff) + 64'(dv4_ff >>> DT_SHIFT));
      un_step  = ins_pkg::sat32(64'(u4_ff) + 64'(du4_ff >>> DT_SHIFT));
      spike_in = (vn_step >= ins_pkg::K_30);
      if (spike_in) begin
         vn_in = param_c_ff;
         un_in = ins_pkg::sat32(64'(un_step) + 64'(param_d_ff));
      end else begin
         vn_in = vn_step;
         un_in = un_step;
      end
   end

   logic [9:0]         raw5_ff;
   logic               spike5_ff;
   logic signed [31:0] vn5_ff, un5_ff, ae5_ff, ai5_ff, an5_ff;
   logic signed [31:0] rge5_ff, rgi5_ff, rgn5_ff;

   always_ff @(posedge clock) begin
      if (move4) begin
         raw5_ff   <= raw4_ff;
         k5_ff     <= k4_ff;
         spike5_ff <= spike_in;
         vn5_ff    <= vn_in;
         un5_ff    <= un_in;
         ae5_ff    <= ae4_ff;
         ai5_ff    <= ai4_ff;
         an5_ff    <= an4_ff;
         rge5_ff   <= rge4_ff;
         rgi5_ff   <= rgi4_ff;
         rgn5_ff   <= rgn4_ff;
      end
   end

   // Stage 5: driving force times conductance for each synapse.
   logic signed [31:0] dve, dvi;

   assign dve = ins_pkg::sat32(64'(E_EXC * 65536) - 64'(vn5_ff));
   assign dvi = ins_pkg::sat32(64'(E_INH * 65536) - 64'(vn5_ff));

   logic [9:0]         raw6_ff;
   logic               spike6_ff;
   logic signed [31:0] te6_ff, ti6_ff, tn6_ff;

   always_ff @(posedge clock) begin
      if (move5) begin
         raw6_ff   <= raw5_ff;
         k6_ff     <= k5_ff;
         spike6_ff <= spike5_ff;
         vn6_ff    <= vn5_ff;
         un6_ff    <= un5_ff;
         ae6_ff    <= ae5_ff;
         ai6_ff    <= ai5_ff;
         an6_ff    <= an5_ff;
         te6_ff    <= ins_pkg::mulq(rge5_ff, dve);
         ti6_ff    <= ins_pkg::mulq(rgi5_ff, dvi);
         tn6_ff    <= ins_pkg::mulq(rgn5_ff, dve);
      end
   end

   // Stage 6: synaptic current sum, write-back and output word.
   assign isum = ins_pkg::sat32(64'(te6_ff) + 64'(ti6_ff) + 64'(tn6_ff));

   logic [9:0]         out_idx_ff;
   logic               out_spk_ff;
   logic signed [31:0] out_pot_ff;

   always_ff @(posedge clock) begin
      if (move6) begin
         out_idx_ff <= raw6_ff;
         out_spk_ff <= spike6_ff;
         out_pot_ff <= vn6_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron_out = out_idx_ff;
   assign rsp_spiked     = out_spk_ff;
   assign rsp_potential  = out_pot_ff;

   // Checks on the clearing pass, the same-neuron interlock and stage 1 holding under a stall.
   `INS_ASSERT_NOW(a_no_accept_in_clear, clock, reset, accept, state_ff == ins_pkg::ST_RUN)
   `INS_ASSERT_NOW(a_no_read_over_write, clock, reset, move_a && move6, k_a != k6_ff)
   `INS_ASSERT_NEXT(a_clear_ends, clock, reset,
                    state_ff == ins_pkg::ST_CLEAR && clear_done, state_ff == ins_pkg::ST_RUN)
   `INS_ASSERT_NEXT(a_stage1_holds, clock, reset, v1_ff && !move1, v1_ff && $stable(k1_ff))

endmodule

>>> tb/testbench.sv
module testbench;

   localparam int NEURON_COUNT = 1024;
   localparam int SPIKE_CAP = 64;
   localparam int DT_BITS = 4;
   localparam longint E_EXC_MV = 0;
   localparam longint E_INH_MV = -70;
   localparam longint NOISE_G = 655;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [3:0] CSR_UNUSED = 4'd12;

   typedef struct {
      logic [9:0] index;
      logic spiked;
      logic [31:0] potential;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [9:0] req_neuron_index = '0;
   logic [6:0] req_exc_spikes = '0;
   logic [6:0] req_inh_spikes = '0;
   logic [7:0] req_noise_spikes = '0;
   logic signed [31:0] req_ext_current = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [9:0] rsp_neuron_out;
   logic rsp_spiked;
   logic signed [31:0] rsp_potential;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Shadow copy of the per-neuron state and the model registers.
   int v_mem[NEURON_COUNT];
   int u_mem[NEURON_COUNT];
   int exc_act[NEURON_COUNT];
   int inh_act[NEURON_COUNT];
   int noise_act[NEURON_COUNT];
   int syn_mem[NEURON_COUNT];
   int a_reg, b_reg, c_reg, d_reg;
   int unsigned exc_rate_reg, inh_rate_reg, exc_gain_reg, inh_gain_reg;

   tick_result_type pending_ticks[$];
   int errors = 0;
   int idle_cycles = 0;
   int rsp_hold = 0;
   bit no_gaps = 1'b0;

   izhikevich_neuron_with_synapses dut (.*);

   always #1 clock = ~clock;

   function automatic int clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return int'(x);
   endfunction

   function automatic int qprod(longint a, longint b);
      return clamp32((a * b) >>> 16);
   endfunction

   function automatic int relax(int r, longint count, longint rate);
      longint diff;
      diff = count * 65536 - longint'(r);
      return clamp32(longint'(r) + ((diff * rate) >>> 16));
   endfunction

   function automatic longint conductance(int r, longint gain, longint e_mv, int v);
      int rg;
      int drive;
      rg = qprod(r, gain);
      drive = clamp32(e_mv * 65536 - longint'(v));
      return longint'(qprod(rg, drive));
   endfunction

   // Advance one neuron by one Euler tick and return the word it produces.
   function automatic tick_result_type euler_tick(logic [9:0] idx, logic [6:0] ne_raw,
                                                  logic [6:0] ni_raw, logic [7:0] nn,
                                                  logic signed [31:0] iext);
      tick_result_type res;
      int k, v, u, vn, un;
      longint dv, du, ne, ni, isum;
      k = idx % NEURON_COUNT;
      v = v_mem[k];
      u = u_mem[k];
      ne = (ne_raw > SPIKE_CAP) ? SPIKE_CAP : ne_raw;
      ni = (ni_raw > SPIKE_CAP) ? SPIKE_CAP : ni_raw;
      dv = longint'(qprod(ins_pkg::K_004, qprod(v, v))) + longint'(qprod(ins_pkg::K_5, v))
         + longint'(ins_pkg::K_140)
         - longint'(u) + longint'(syn_mem[k]) + longint'(iext);
      dv = clamp32(dv);
      du = qprod(a_reg, clamp32(longint'(qprod(b_reg, v)) - longint'(u)));
      vn = clamp32(longint'(v) + (dv >>> DT_BITS));
      un = clamp32(longint'(u) + (du >>> DT_BITS));
      res.spiked = (vn >= ins_pkg::K_30);
      if (res.spiked) begin
         vn = c_reg;
         un = clamp32(longint'(un) + longint'(d_reg));
      end
      v_mem[k] = vn;
      u_mem[k] = un;
      exc_act[k] = relax(exc_act[k], ne, exc_rate_reg);
      inh_act[k] = relax(inh_act[k], ni, inh_rate_reg);
      noise_act[k] = relax(noise_act[k], longint'(nn), exc_rate_reg);
      isum = conductance(exc_act[k], exc_gain_reg, E_EXC_MV, vn)
           + conductance(inh_act[k], inh_gain_reg, E_INH_MV, vn)
           + conductance(noise_act[k], NOISE_G, E_EXC_MV, vn);
      syn_mem[k] = clamp32(isum);
      res.index = idx;
      res.potential = vn;
      return res;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // Send one tick word; called and returning at a falling edge.
   task automatic send_tick(logic [9:0] idx, logic [6:0] ne, logic [6:0] ni,
                            logic [7:0] nn, logic signed [31:0] iext);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_neuron_index <= idx;
      req_exc_spikes <= ne;
      req_inh_spikes <= ni;
      req_noise_spikes <= nn;
      req_ext_current <= iext;
      do @(posedge clock); while (!req_ready);
      pending_ticks.push_back(euler_tick(idx, ne, ni, nn, iext));
      @(negedge clock);
   endtask

   // Let every expected word arrive, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_ticks.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; only used while the block is idle.
   task automatic write_reg(logic [3:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         ins_pkg::CSR_PARAM_A: a_reg = data;
         ins_pkg::CSR_PARAM_B: b_reg = data;
         ins_pkg::CSR_PARAM_C: c_reg = data;
         ins_pkg::CSR_PARAM_D: d_reg = data;
         ins_pkg::CSR_EXC_RATE: exc_rate_reg = 32'(data[15:0]);
         ins_pkg::CSR_INH_RATE: inh_rate_reg = 32'(data[15:0]);
         ins_pkg::CSR_EXC_GAIN: exc_gain_reg = 32'(data[23:0]);
         ins_pkg::CSR_INH_GAIN: inh_gain_reg = 32'(data[23:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(int a, int b, int c, int d, int er, int ir, int eg, int ig);
      write_reg(ins_pkg::CSR_PARAM_A, a);
      write_reg(ins_pkg::CSR_PARAM_B, b);
      write_reg(ins_pkg::CSR_PARAM_C, c);
      write_reg(ins_pkg::CSR_PARAM_D, d);
      write_reg(ins_pkg::CSR_EXC_RATE, er);
      write_reg(ins_pkg::CSR_INH_RATE, ir);
      write_reg(ins_pkg::CSR_EXC_GAIN, eg);
      write_reg(ins_pkg::CSR_INH_GAIN, ig);
   endtask

   // Ticks at the reset settings: field extremes and counts above the cap.
   task automatic test_reset_settings();
      send_tick(10'd0, 7'd0, 7'd0, 8'd0, 32'sd0);
      send_tick(10'd1023, 7'd127, 7'd127, 8'd255, 32'sh7FFFFFFF);
      send_tick(10'd512, 7'd64, 7'd65, 8'd1, 32'sh80000000);
      send_tick(10'd1023, 7'd1, 7'd64, 8'd128, -32'sd1);
      drain();
   endtask

   // Saturation at the range limits and spike counts around the cap.
   task automatic test_extremes();
      write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      send_tick(10'd2, 7'd127, 7'd0, 8'd255, 32'sh7FFFFFFF);
      send_tick(10'd3, 7'd0, 7'd127, 8'd0, 32'sh80000000);
      send_tick(10'd2, 7'd64, 7'd64, 8'd255, 32'sh80000000);
      send_tick(10'd3, 7'd63, 7'd65, 8'd7, 32'sh7FFFFFFF);
      send_tick(10'd2, 7'd0, 7'd0, 8'd0, 32'sd0);
      drain();
      write_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                16'd0, 16'd0, 24'd0, 24'd0);
      send_tick(10'd4, 7'd127, 7'd127, 8'd255, 32'sh7FFFFFFF);
      send_tick(10'd4, 7'd0, 7'd0, 8'd0, 32'sh80000000);
      send_tick(10'd5, 7'd100, 7'd3, 8'd200, 32'sh40000000);
      drain();
   endtask

   // A neuron driven by strong current spikes and resets, also back to back.
   task automatic test_spiking();
      write_all(1311, 13107, -4259840, 524288, 6554, 3277, 32768, 32768);
      repeat (10) send_tick(10'd7, 7'd5, 7'd2, 8'd3, 32'sd200 <<< 16);
      drain();
   endtask

   // Mostly physiological ticks on a few neurons so state evolves, plus noise.
   task automatic random_phase(int count);
      logic [9:0] idx;
      logic [6:0] ne, ni;
      logic [7:0] nn;
      logic signed [31:0] iext;
      repeat (count) begin
         if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 9) < 7) begin
            idx = 10'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0) idx = 10'd1023 - idx;
            ne = 7'($urandom_range(0, 70));
            ni = 7'($urandom_range(0, 70));
            nn = 8'($urandom_range(0, 40));
            iext = $urandom_range(0, 30) <<< 16;
            iext = iext + $urandom_range(0, 65535);
         end else begin
            idx = 10'($urandom);
            ne = 7'($urandom);
            ni = 7'($urandom);
            nn = 8'($urandom);
            iext = $urandom;
         end
         send_tick(idx, ne, ni, nn, iext);
      end
      drain();
   endtask

   task automatic test_random();
      random_phase(250);
      write_all(1311, 6554, -3276800, 131072, 1000, 500, 65536, 200000);
      random_phase(250);
      write_all(6554, 16384, -4259840, 0, 65535, 65535, 16777215, 16777215);
      random_phase(250);
      write_all($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
      random_phase(200);
      write_all(1311, 13107, -4259840, 524288, 3277, 1638, 8192, 4096);
      random_phase(280);
   endtask

   initial begin
      a_reg = ins_pkg::PARAM_A_RESET;
      b_reg = ins_pkg::PARAM_B_RESET;
      c_reg = ins_pkg::PARAM_C_RESET;
      d_reg = ins_pkg::PARAM_D_RESET;
      exc_rate_reg = 0;
      inh_rate_reg = 0;
      exc_gain_reg = 0;
      inh_gain_reg = 0;
      for (int i = 0; i < NEURON_COUNT; i++) begin
         v_mem[i] = ins_pkg::V_RESET;
         u_mem[i] = ins_pkg::U_RESET;
         exc_act[i] = 0;
         inh_act[i] = 0;
         noise_act[i] = 0;
         syn_mem[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_extremes();
      test_spiking();
      test_random();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Response readiness: stall for a drawn number of cycles after each word.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response word with the oldest expectation; watch for hangs.
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_hold = no_gaps ? 0 : $urandom_range(0, 16);
         if (pending_ticks.size() == 0) begin
            report("unexpected word, neuron", rsp_neuron_out, -1);
         end else begin
            want = pending_ticks.pop_front();
            if (rsp_neuron_out !== want.index)
               report("neuron_out", rsp_neuron_out, want.index);
            if (rsp_spiked !== want.spiked)
               report("spiked", rsp_spiked, want.spiked);
            if (rsp_potential !== want.potential)
               report("potential", rsp_potential, $signed(want.potential));
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles = 0;
      end else if (req_valid || pending_ticks.size() > 0) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end
endmodule

>>> sim.f
+incdir+rtl
rtl/ins_pkg.sv
rtl/izhikevich_neuron_with_synapses.sv
tb/testbench.sv
